// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that cond holds at every edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a implies b in the same cycle.
`define ASSERT_IMPLY(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`endif

// File: src/cnlc_pkg.sv
// Types and constants of the card number Luhn classifier.
package cnlc_pkg;
  localparam int NUM_POS = 19;
  localparam int NUM_W = 63;
  localparam int REM_W = 64;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_15 = 2'd1;
  localparam logic [1:0] CLASS_4 = 2'd2;
  localparam logic [1:0] CLASS_5X = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [3:0]       tot;
    logic [4:0]       cnt;
    logic             ovf;
    logic [3:0][3:0]  dig;
  } st_t;

  function automatic logic [REM_W-1:0] pow10(int k);
    logic [REM_W-1:0] r;
    r = 64'd1;
    for (int i = 0; i < k; i++) r = r * 64'd10;
    return r;
  endfunction
endpackage

// File: src/cnlc_if.sv
// Handshake channels for card numbers and classification results.
interface cnlc_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] card_number;
  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

interface cnlc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] card_class;
  logic       checksum_ok;
  logic [4:0] digit_count;
  modport source (output valid, output card_class, output checksum_ok, output digit_count,
                  input ready);
  modport sink (input valid, input card_class, input checksum_ok, input digit_count,
                output ready);
endinterface

// File: src/cnlc_digit_stage.sv
// One pipeline stage that extracts the decimal digit at one power of ten.
module cnlc_digit_stage #(
  parameter int K = 0,
  parameter int MAX_DIGITS = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  cnlc_pkg::st_t st_i,
  output cnlc_pkg::st_t st_o
);
  localparam logic [cnlc_pkg::REM_W-1:0] P = cnlc_pkg::pow10(K);
  localparam int DIG_IDX = (K >= 12 && K <= 15) ? K - 12 : 0;

  cnlc_pkg::st_t st_r;
  cnlc_pkg::st_t st_nxt;
  logic [3:0] d;
  logic [cnlc_pkg::REM_W-1:0] sub;
  logic [4:0] dbl;
  logic [3:0] v;
  logic [4:0] sum;

  always_comb begin
    d = 4'd0;
    sub = '0;
    for (int j = 1; j < 10; j++) begin
      if (st_i.rem >= P * 64'(j)) begin
        d = 4'(j);
        sub = P * 64'(j);
      end
    end
    dbl = {d, 1'b0};
    if ((K % 2) == 1) begin
      v = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      v = d;
    end
    if (K >= MAX_DIGITS) v = 4'd0;
    sum = {1'b0, st_i.tot} + {1'b0, v};
    st_nxt = st_i;
    st_nxt.rem = st_i.rem - sub;
    st_nxt.tot = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
    if (d != 4'd0 && st_i.cnt == 5'd0) st_nxt.cnt = 5'(K + 1);
    if (K >= MAX_DIGITS && d != 4'd0) st_nxt.ovf = 1'b1;
    if (K >= 12 && K <= 15) st_nxt.dig[DIG_IDX] = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_nxt.valid;
    end
    if (en) begin
      st_r.rem <= st_nxt.rem;
      st_r.tot <= st_nxt.tot;
      st_r.cnt <= st_nxt.cnt;
      st_r.ovf <= st_nxt.ovf;
      st_r.dig <= st_nxt.dig;
    end
  end

  assign st_o = st_r;
endmodule

// File: src/card_number_luhn_classifier.sv
// Pipeline: 19 digit stages, then the registered output stage, between an accepted item and its result.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Each stage extracts one decimal digit with a bank of constant compares.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// No state persists between items.
// Top level: pipelined Luhn check and card number classifier.
`include "assert_macros.svh"
module card_number_luhn_classifier #(
  parameter int MAX_DIGITS = 19
) (
  input  logic clk,
  input  logic rst_n,
  cnlc_in_if.sink in_ch,
  cnlc_out_if.source out_ch
);
  cnlc_pkg::st_t st [cnlc_pkg::NUM_POS+1];
  logic en;
  logic out_valid_r;
  logic [1:0] card_class_r;
  logic checksum_ok_r;
  logic [4:0] digit_count_r;
  logic [1:0] cls_nxt;
  logic [4:0] cnt_nxt;
  cnlc_pkg::st_t fin;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    st[0].valid = in_ch.valid;
    st[0].rem = {1'b0, in_ch.card_number};
    st[0].tot = 4'd0;
    st[0].cnt = 5'd0;
    st[0].ovf = 1'b0;
    st[0].dig = '0;
  end

  for (genvar g = 0; g < cnlc_pkg::NUM_POS; g++) begin : g_stage
    cnlc_digit_stage #(
      .K(cnlc_pkg::NUM_POS - 1 - g),
      .MAX_DIGITS(MAX_DIGITS)
    ) u_stage (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .st_i(st[g]),
      .st_o(st[g+1])
    );
  end

  assign fin = st[cnlc_pkg::NUM_POS];

  always_comb begin
    cnt_nxt = fin.ovf ? 5'(MAX_DIGITS) : fin.cnt;
    cls_nxt = cnlc_pkg::CLASS_NONE;
    if (fin.tot == 4'd0 && !fin.ovf) begin
      if (fin.cnt == 5'd15) begin
        if (fin.dig[2] == 4'd3 && (fin.dig[1] == 4'd4 || fin.dig[1] == 4'd7)) begin
          cls_nxt = cnlc_pkg::CLASS_15;
        end
      end else if (fin.cnt == 5'd13) begin
        if (fin.dig[0] == 4'd4) cls_nxt = cnlc_pkg::CLASS_4;
      end else if (fin.cnt == 5'd16) begin
        if (fin.dig[3] == 4'd4) begin
          cls_nxt = cnlc_pkg::CLASS_4;
        end else if (fin.dig[3] == 4'd5 && fin.dig[2] >= 4'd1 && fin.dig[2] <= 4'd5) begin
          cls_nxt = cnlc_pkg::CLASS_5X;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
    if (en) begin
      card_class_r <= cls_nxt;
      checksum_ok_r <= (fin.tot == 4'd0);
      digit_count_r <= cnt_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.card_class = card_class_r;
  assign out_ch.checksum_ok = checksum_ok_r;
  assign out_ch.digit_count = digit_count_r;

  `ASSERT_IMPLY(a_count_max, out_valid_r, digit_count_r <= 5'(MAX_DIGITS), "digit count too big")
  `ASSERT_IMPLY(a_class_ok, out_valid_r && card_class_r != cnlc_pkg::CLASS_NONE, checksum_ok_r, "class without checksum")
  `ASSERT_IMPLY(a_class15_len, out_valid_r && card_class_r == cnlc_pkg::CLASS_15, digit_count_r == 5'd15, "class 1 length")
endmodule
